// File: rtl/mss_pkg.sv
// types, constants and register map for the spin sequencer
package mss_pkg;

	localparam int PosBits  = 10;
	localparam int AddrBits = 4;
	localparam int DataBits = 32;

	localparam logic [7:0]  RampStepsRst = 8'd100;
	localparam logic [15:0] TicksPerSecRst = 16'd10000;
	localparam logic [7:0]  CoastSecRst = 8'd5;
	localparam logic [9:0]  ToleranceRst = 10'd5;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_ABORT = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_RAMP  = 3'd1,
		PH_HOLD  = 3'd2,
		PH_COAST = 3'd3,
		PH_POS   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REG_RAMP_STEPS = 2'd0,
		REG_TICKS_SEC  = 2'd1,
		REG_COAST_SEC  = 2'd2,
		REG_TOLERANCE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [PosBits-1:0] position;
		logic [11:0]        hold_seconds;
	} item_t;

	typedef struct packed {
		logic   spin_out;
		logic   servo_on;
		phase_t phase;
		logic   done_res;
	} result_t;

	typedef struct packed {
		logic [7:0]         ramp_steps;
		logic [15:0]        ticks_per_second;
		logic [7:0]         coast_seconds;
		logic [PosBits-1:0] tolerance;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic   busy;
	} status_t;

endpackage

// File: rtl/mss_chan_if.sv
// valid/ready channels for sequencer items and results
interface mss_item_if;
	import mss_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [PosBits-1:0] position;
	logic [11:0]        hold_seconds;
	modport source (output valid, action, position, hold_seconds, input ready);
	modport sink (input valid, action, position, hold_seconds, output ready);
endinterface

interface mss_result_if;
	logic       valid;
	logic       ready;
	logic       spin_out;
	logic       servo_on;
	logic [2:0] phase;
	logic       done_res;
	modport source (output valid, spin_out, servo_on, phase, done_res, input ready);
	modport sink (input valid, spin_out, servo_on, phase, done_res, output ready);
endinterface

// File: rtl/mss_seq_core.sv
// sequencer state and single-pass next-state logic
module mss_seq_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  mss_pkg::item_t   item,
	input  mss_pkg::cfg_t    cfg,
	output mss_pkg::result_t res,
	output mss_pkg::status_t st
);
	import mss_pkg::*;

	phase_t             phase_q, phase_d;
	logic [7:0]         ramp_index_q, ramp_index_d;
	logic [7:0]         period_tick_q, period_tick_d;
	logic [11:0]        second_count_q, second_count_d;
	logic [15:0]        tick_count_q, tick_count_d;
	logic [PosBits-1:0] home_q, home_d;
	logic [11:0]        hold_q, hold_d;

	logic [7:0]         pt_inc;
	logic [15:0]        tick_inc;
	logic               sec_wrap;
	logic [11:0]        sec_next;
	logic [11:0]        sec_limit;
	logic [PosBits-1:0] home_dist;

	// skip phases of zero length
	function automatic phase_t enter_ph(phase_t ph, logic [7:0] rs, logic [11:0] ht,
			logic [7:0] cs);
		phase_t p;
		p = ph;
		if (p == PH_RAMP && rs == 8'd0) p = PH_HOLD;
		if (p == PH_HOLD && ht == 12'd0) p = PH_COAST;
		if (p == PH_COAST && cs == 8'd0) p = PH_POS;
		return p;
	endfunction

	function automatic result_t show(phase_t ph, logic [7:0] pt, logic [7:0] ri);
		result_t r;
		r.spin_out = (ph == PH_HOLD) || (ph == PH_RAMP && pt < ri);
		r.servo_on = (ph == PH_POS);
		r.phase    = ph;
		r.done_res = 1'b0;
		return r;
	endfunction

	assign pt_inc    = 8'(period_tick_q + 8'd1);
	assign tick_inc  = 16'(tick_count_q + 16'd1);
	assign sec_wrap  = tick_inc >= cfg.ticks_per_second;
	assign sec_next  = sec_wrap ? 12'(second_count_q + 12'd1) : second_count_q;
	assign sec_limit = (phase_q == PH_HOLD) ? hold_q : {4'd0, cfg.coast_seconds};
	assign home_dist = (home_q > item.position) ? PosBits'(home_q - item.position)
	                                            : PosBits'(item.position - home_q);

	always_comb begin
		phase_d        = phase_q;
		ramp_index_d   = ramp_index_q;
		period_tick_d  = period_tick_q;
		second_count_d = second_count_q;
		tick_count_d   = tick_count_q;
		home_d         = home_q;
		hold_d         = hold_q;
		res            = show(phase_q, period_tick_q, ramp_index_q);

		case (item.action)
			ACT_ABORT: begin
				phase_d        = PH_IDLE;
				ramp_index_d   = 8'd0;
				period_tick_d  = 8'd0;
				second_count_d = 12'd0;
				tick_count_d   = 16'd0;
				res            = show(PH_IDLE, 8'd0, 8'd0);
			end
			ACT_START: begin
				if (phase_q == PH_IDLE) begin
					home_d         = item.position;
					hold_d         = item.hold_seconds;
					phase_d        = enter_ph(PH_RAMP, cfg.ramp_steps, item.hold_seconds,
					                          cfg.coast_seconds);
					ramp_index_d   = 8'd0;
					period_tick_d  = 8'd0;
					second_count_d = 12'd0;
					tick_count_d   = 16'd0;
					res            = show(phase_d, 8'd0, 8'd0);
				end
			end
			ACT_TICK: begin
				case (phase_q)
					PH_IDLE: ;
					PH_RAMP: begin
						if (pt_inc >= cfg.ramp_steps) begin
							period_tick_d = 8'd0;
							if (ramp_index_q >= cfg.ramp_steps) begin
								phase_d      = enter_ph(PH_HOLD, cfg.ramp_steps, hold_q,
								                        cfg.coast_seconds);
								ramp_index_d = 8'd0;
							end else begin
								ramp_index_d = 8'(ramp_index_q + 8'd1);
							end
						end else begin
							period_tick_d = pt_inc;
						end
					end
					PH_HOLD, PH_COAST: begin
						if (sec_next >= sec_limit) begin
							// timer expired: next phase starts with cleared counters
							phase_d        = enter_ph((phase_q == PH_HOLD) ? PH_COAST : PH_POS,
							                          cfg.ramp_steps, hold_q, cfg.coast_seconds);
							second_count_d = 12'd0;
							tick_count_d   = 16'd0;
						end else begin
							second_count_d = sec_next;
							tick_count_d   = sec_wrap ? 16'd0 : tick_inc;
						end
					end
					PH_POS: begin
						if (home_dist <= cfg.tolerance) begin
							res.servo_on   = 1'b0;
							res.done_res   = 1'b1;
							phase_d        = PH_IDLE;
							ramp_index_d   = 8'd0;
							period_tick_d  = 8'd0;
							second_count_d = 12'd0;
							tick_count_d   = 16'd0;
						end
					end
					default: begin
						phase_d        = PH_IDLE;
						ramp_index_d   = 8'd0;
						period_tick_d  = 8'd0;
						second_count_d = 12'd0;
						tick_count_d   = 16'd0;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			ramp_index_q   <= 8'd0;
			period_tick_q  <= 8'd0;
			second_count_q <= 12'd0;
			tick_count_q   <= 16'd0;
			home_q         <= '0;
			hold_q         <= 12'd0;
		end else if (fire) begin
			phase_q        <= phase_d;
			ramp_index_q   <= ramp_index_d;
			period_tick_q  <= period_tick_d;
			second_count_q <= second_count_d;
			tick_count_q   <= tick_count_d;
			home_q         <= home_d;
			hold_q         <= hold_d;
		end
	end

	assign st.phase = phase_q;
	assign st.busy  = (phase_q != PH_IDLE);

endmodule

// File: rtl/motor_softstart_spin_sequencer_unit.sv
// spin sequencer top level: config registers, input stage and result register
//
//   channel  | dir | transfer when           | payload
//   item     | in  | item.valid & ready     | action, position, hold_seconds
//   result   | out | result.valid & ready   | spin_out, servo_on, phase, done_res
//   apb      | in  | psel&penable&pwrite    | ramp_steps, ticks_per_second, coast, tol
//
// one item per cycle sustained while results are taken; each item passes the input
// stage and then the result register before its result is valid
// the result register frees the input stage whenever it is empty or taken
// reset clears the sequencer to idle and loads the register defaults
// a stalled result holds the input stage; item.ready drops only then
module motor_softstart_spin_sequencer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	mss_item_if.sink                     item,
	mss_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mss_pkg::AddrBits-1:0] paddr,
	input  logic [mss_pkg::DataBits-1:0] pwdata,
	output logic [mss_pkg::DataBits-1:0] prdata,
	output logic                         pready
);
	import mss_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	result_t res_d;
	status_t st;
	logic    adv;
	logic    fire_s1;
	logic    cfg_wr;
	logic [1:0] reg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[AddrBits-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_steps       <= RampStepsRst;
			cfg_q.ticks_per_second <= TicksPerSecRst;
			cfg_q.coast_seconds    <= CoastSecRst;
			cfg_q.tolerance        <= ToleranceRst;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RAMP_STEPS: cfg_q.ramp_steps       <= pwdata[7:0];
				REG_TICKS_SEC:  cfg_q.ticks_per_second <= pwdata[15:0];
				REG_COAST_SEC:  cfg_q.coast_seconds    <= pwdata[7:0];
				REG_TOLERANCE:  cfg_q.tolerance        <= pwdata[PosBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RAMP_STEPS: prdata = {24'd0, cfg_q.ramp_steps};
			REG_TICKS_SEC:  prdata = {16'd0, cfg_q.ticks_per_second};
			REG_COAST_SEC:  prdata = {24'd0, cfg_q.coast_seconds};
			REG_TOLERANCE:  prdata = {{(DataBits-PosBits){1'b0}}, cfg_q.tolerance};
			default:        prdata = '0;
		endcase
	end

	// pipeline control
	assign adv        = !out_valid_q || result.ready;
	assign fire_s1    = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (adv) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action       <= item.action;
			item_s1.position     <= item.position;
			item_s1.hold_seconds <= item.hold_seconds;
		end
		if (fire_s1) res_q <= res_d;
	end

	mss_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_d),
		.st     (st)
	);

	assign result.valid    = out_valid_q;
	assign result.spin_out = res_q.spin_out;
	assign result.servo_on = res_q.servo_on;
	assign result.phase    = res_q.phase;
	assign result.done_res = res_q.done_res;

	// done only on the tick that leaves positioning with the drive off
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> res_q.phase == PH_POS && !res_q.servo_on)
		else $error("done without positioning end");

	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.spin_out && res_q.servo_on))
		else $error("spin and servo both on");

	a_abort_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.action == ACT_ABORT |=> st.phase == PH_IDLE && !st.busy)
		else $error("abort did not return to idle");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready && valid_s1 |-> !item.ready)
		else $error("input taken while both stages full");

endmodule

// File: verif/tb_motor_softstart_spin_sequencer_unit.sv
// self-checking testbench for the soft-start spin sequencer unit
`timescale 1ns / 100ps

module tb_motor_softstart_spin_sequencer_unit;
	import mss_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int HoldOffCycles = 90;
	localparam int RandomItems = 500;
	localparam int MaxReports = 20;

	bit clk;
	bit arst_n;

	bit                psel;
	bit                penable;
	bit                pwrite;
	bit [AddrBits-1:0] paddr;
	bit [DataBits-1:0] pwdata;
	logic [DataBits-1:0] prdata;
	logic              pready;

	mss_item_if   item_ch ();
	mss_result_if result_ch ();

	// sender and receiver levels, two-state so they are known from time zero
	bit               drv_valid;
	bit [1:0]         drv_action;
	bit [PosBits-1:0] drv_position;
	bit [11:0]        drv_hold;
	bit               rcv_ready;

	assign item_ch.valid        = drv_valid;
	assign item_ch.action       = drv_action;
	assign item_ch.position     = drv_position;
	assign item_ch.hold_seconds = drv_hold;
	assign result_ch.ready      = rcv_ready;

	motor_softstart_spin_sequencer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// commands waiting to be sent and drive levels still to come back
	item_t   cmd_q[$];
	result_t levels_due_q[$];

	// register copies
	logic [7:0]         cfg_ramp;
	logic [15:0]        cfg_tps;
	logic [7:0]         cfg_coast;
	logic [PosBits-1:0] cfg_tol;

	// sequencer copy
	phase_t             seq_phase;
	logic [7:0]         seq_ramp_idx;
	logic [7:0]         seq_period;
	logic [11:0]        seq_secs;
	logic [15:0]        seq_ticks;
	logic [PosBits-1:0] seq_home;
	logic [11:0]        seq_hold_secs;

	int err_cnt;
	int sent_cnt;
	int checked_cnt;
	int done_cnt;
	int reg_write_cnt;
	bit [4:0] phases_seen;

	int holdoff_req;
	int holdoff_ack;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		err_cnt++;
		if (err_cnt <= MaxReports)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic void sequencer_reset();
		cfg_ramp      = RampStepsRst;
		cfg_tps       = TicksPerSecRst;
		cfg_coast     = CoastSecRst;
		cfg_tol       = ToleranceRst;
		seq_phase     = PH_IDLE;
		seq_ramp_idx  = '0;
		seq_period    = '0;
		seq_secs      = '0;
		seq_ticks     = '0;
		seq_home      = '0;
		seq_hold_secs = '0;
	endfunction

	// zero-length phases fall straight through to the next one
	function automatic void enter_phase(input phase_t p);
		seq_ramp_idx = '0;
		seq_period   = '0;
		seq_secs     = '0;
		seq_ticks    = '0;
		seq_phase    = p;
		if (seq_phase == PH_RAMP && cfg_ramp == 8'd0)
			seq_phase = PH_HOLD;
		if (seq_phase == PH_HOLD && seq_hold_secs == 12'd0)
			seq_phase = PH_COAST;
		if (seq_phase == PH_COAST && cfg_coast == 8'd0)
			seq_phase = PH_POS;
	endfunction

	function automatic bit seconds_elapsed(input logic [11:0] limit);
		seq_ticks = seq_ticks + 16'd1;
		if (seq_ticks >= cfg_tps) begin
			seq_ticks = '0;
			seq_secs  = seq_secs + 12'd1;
		end
		return seq_secs >= limit;
	endfunction

	function automatic result_t drive_levels(input bit done);
		result_t r;
		r.spin_out = (seq_phase == PH_HOLD) ||
			(seq_phase == PH_RAMP && seq_period < seq_ramp_idx);
		r.servo_on = (seq_phase == PH_POS);
		r.phase    = seq_phase;
		r.done_res = done;
		return r;
	endfunction

	// drive levels caused by one command; advances the sequencer copy
	function automatic result_t sequence_step(input item_t it);
		result_t r;
		int      home_dist;
		if (it.action == ACT_ABORT) begin
			enter_phase(PH_IDLE);
			return drive_levels(1'b0);
		end
		if (it.action != ACT_TICK) begin
			if (it.action == ACT_START && seq_phase == PH_IDLE) begin
				seq_home      = it.position;
				seq_hold_secs = it.hold_seconds;
				enter_phase(PH_RAMP);
			end
			return drive_levels(1'b0);
		end
		r = drive_levels(1'b0);
		case (seq_phase)
			PH_RAMP: begin
				seq_period = seq_period + 8'd1;
				if (seq_period >= cfg_ramp) begin
					seq_period = '0;
					if (seq_ramp_idx >= cfg_ramp)
						enter_phase(PH_HOLD);
					else
						seq_ramp_idx = seq_ramp_idx + 8'd1;
				end
			end
			PH_HOLD: begin
				if (seconds_elapsed(seq_hold_secs))
					enter_phase(PH_COAST);
			end
			PH_COAST: begin
				if (seconds_elapsed({4'd0, cfg_coast}))
					enter_phase(PH_POS);
			end
			PH_POS: begin
				home_dist = (seq_home > it.position) ? int'(seq_home) - int'(it.position) :
					int'(it.position) - int'(seq_home);
				if (home_dist <= int'(cfg_tol)) begin
					r.servo_on = 1'b0;
					r.done_res = 1'b1;
					enter_phase(PH_IDLE);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// sender: bursts of random length with random gaps
	int    gap_left;
	int    burst_left;
	item_t next_cmd;
	item_t sent_cmd;

	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			sequencer_reset();
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (drv_valid && item_ch.ready) begin
				sent_cmd.action       = drv_action;
				sent_cmd.position     = drv_position;
				sent_cmd.hold_seconds = drv_hold;
				levels_due_q.push_back(sequence_step(sent_cmd));
				sent_cnt++;
			end
			if (!drv_valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					drv_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					next_cmd = cmd_q.pop_front();
					drv_valid    <= 1'b1;
					drv_action   <= next_cmd.action;
					drv_position <= next_cmd.position;
					drv_hold     <= next_cmd.hold_seconds;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						burst_left = $urandom_range(1, 30);
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: segments of different stall patterns, plus requested long hold-offs
	int       holdoff_left;
	int       seg_left;
	int       seg_mode;
	bit [7:0] stall_pattern;

	always @(posedge clk) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			holdoff_left  = 0;
			seg_left      = 0;
			seg_mode      = 0;
			stall_pattern = 8'b1011_0110;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			rcv_ready <= 1'b0;
		end else if (holdoff_req != holdoff_ack) begin
			holdoff_ack  = holdoff_req;
			holdoff_left = HoldOffCycles;
			rcv_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 3);
				seg_left = $urandom_range(5, 60);
			end else begin
				seg_left--;
			end
			stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
			case (seg_mode)
				0: rcv_ready <= 1'b1;
				1: rcv_ready <= $urandom_range(0, 1);
				2: rcv_ready <= ($urandom_range(0, 3) != 0);
				default: rcv_ready <= stall_pattern[0];
			endcase
		end
	end

	// result checker
	result_t want;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && rcv_ready) begin
			checked_cnt++;
			if (levels_due_q.size() == 0) begin
				report_mismatch("result with nothing outstanding, phase", result_ch.phase, 0);
			end else begin
				want = levels_due_q.pop_front();
				if (result_ch.spin_out !== want.spin_out)
					report_mismatch("spin_out", result_ch.spin_out, want.spin_out);
				if (result_ch.servo_on !== want.servo_on)
					report_mismatch("servo_on", result_ch.servo_on, want.servo_on);
				if (result_ch.phase !== want.phase)
					report_mismatch("phase", result_ch.phase, want.phase);
				if (result_ch.done_res !== want.done_res)
					report_mismatch("done_res", result_ch.done_res, want.done_res);
				if (want.done_res)
					done_cnt++;
				if (int'(want.phase) < 5)
					phases_seen[want.phase] = 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer or register access
	int quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n || (drv_valid && item_ch.ready) || (result_ch.valid && rcv_ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("watchdog: no transfer for %0d cycles", QuietLimit);
			$display("TEST FAILED");
			$finish;
		end
	end

	// register write, then read back through the same port
	task automatic reg_write(input reg_idx_t idx, input int unsigned val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_RAMP_STEPS: cfg_ramp  = val[7:0];
			REG_TICKS_SEC:  cfg_tps   = val[15:0];
			REG_COAST_SEC:  cfg_coast = val[7:0];
			default:        cfg_tol   = val[PosBits-1:0];
		endcase
		reg_write_cnt++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== val)
			report_mismatch("register read back", prdata, val);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int ramp, input int tps, input int coast, input int tol);
		reg_write(REG_RAMP_STEPS, ramp);
		reg_write(REG_TICKS_SEC, tps);
		reg_write(REG_COAST_SEC, coast);
		reg_write(REG_TOLERANCE, tol);
	endtask

	// wait until every command has been sent and every result has come back
	task automatic drain();
		while (cmd_q.size() != 0 || drv_valid || levels_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void push_cmd(input action_t act, input int pos, input int hold);
		item_t c;
		c.action       = act;
		c.position     = pos[PosBits-1:0];
		c.hold_seconds = hold[11:0];
		cmd_q.push_back(c);
	endfunction

	function automatic int pick_hold();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 3);
		if (r < 90)
			return $urandom_range(4, 10);
		return $urandom_range(0, 4095);
	endfunction

	// encoder reading: often close to home so positioning can finish
	function automatic int pick_position(input int home);
		int w;
		int p;
		if ($urandom_range(0, 9) < 4)
			return $urandom_range(0, (1 << PosBits) - 1);
		w = $urandom_range(0, 48);
		p = home + $urandom_range(0, 2 * w) - w;
		if (p < 0)
			p = 0;
		if (p > (1 << PosBits) - 1)
			p = (1 << PosBits) - 1;
		return p;
	endfunction

	// one start followed by a run of ticks, with the odd stray command
	function automatic void gen_spin_run(inout int n);
		int home;
		int hold;
		int len;
		int r;
		home = $urandom_range(0, (1 << PosBits) - 1);
		hold = pick_hold();
		push_cmd(ACT_START, home, hold);
		n++;
		len = $urandom_range(5, 70);
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				push_cmd(ACT_START, $urandom_range(0, 1023), $urandom_range(0, 4095));
			end else if (r < 5) begin
				push_cmd(ACT_NONE, $urandom_range(0, 1023), $urandom_range(0, 4095));
			end else if (r < 7) begin
				push_cmd(ACT_ABORT, $urandom_range(0, 1023), $urandom_range(0, 4095));
				n++;
				return;
			end else begin
				push_cmd(ACT_TICK, pick_position(home), $urandom_range(0, 4095));
				n++;
			end
		end
		// long holds would otherwise block the following runs
		if (hold > 10 || $urandom_range(0, 2) == 0) begin
			push_cmd(ACT_ABORT, $urandom_range(0, 1023), $urandom_range(0, 4095));
			n++;
		end
	endfunction

	function automatic void gen_noise(inout int n);
		int cnt;
		cnt = $urandom_range(1, 8);
		for (int k = 0; k < cnt; k++) begin
			push_cmd(action_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
				$urandom_range(0, 4095));
			n++;
		end
	endfunction

	initial begin
		int n;
		int target;
		int round;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults: idle tick, action three, abort, start at the field maxima,
		// start and action three while busy, abort out of the ramp
		push_cmd(ACT_TICK, 0, 0);
		push_cmd(ACT_NONE, 1023, 4095);
		push_cmd(ACT_ABORT, 0, 0);
		push_cmd(ACT_START, 1023, 4095);
		push_cmd(ACT_TICK, 1023, 4095);
		push_cmd(ACT_TICK, 1023, 0);
		push_cmd(ACT_START, 0, 0);
		push_cmd(ACT_NONE, 0, 0);
		push_cmd(ACT_ABORT, 0, 0);
		push_cmd(ACT_TICK, 512, 2048);
		drain();

		// every phase length zero and widest tolerance: straight to positioning;
		// zero ticks per second makes each tick a whole second
		set_config(0, 0, 0, 1023);
		push_cmd(ACT_START, 0, 0);
		push_cmd(ACT_TICK, 1023, 0);
		push_cmd(ACT_START, 300, 2);
		push_cmd(ACT_TICK, 0, 0);
		push_cmd(ACT_TICK, 0, 0);
		push_cmd(ACT_TICK, 0, 0);
		drain();

		// ramp step count lowered part way through a ramp, exact home needed
		set_config(3, 1, 1, 0);
		push_cmd(ACT_START, 100, 1);
		repeat (5) push_cmd(ACT_TICK, 101, 0);
		drain();
		reg_write(REG_RAMP_STEPS, 1);
		repeat (4) push_cmd(ACT_TICK, 101, 0);
		repeat (2) push_cmd(ACT_TICK, 100, 0);
		drain();

		// largest ramp, tick and coast settings, aborted early
		set_config(255, 65535, 255, 0);
		push_cmd(ACT_START, 0, 4095);
		push_cmd(ACT_TICK, 0, 0);
		push_cmd(ACT_ABORT, 0, 0);
		drain();

		n = 0;
		round = 0;
		while (n < RandomItems) begin
			set_config(($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5),
				$urandom_range(0, 4), $urandom_range(0, 3),
				($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 40));
			target = n + 85;
			while (n < target) begin
				if ($urandom_range(0, 6) == 0)
					gen_noise(n);
				else
					gen_spin_run(n);
			end
			// first round: receiver holds off while the sender keeps pushing
			if (round == 0)
				holdoff_req++;
			round++;
			drain();
		end

		repeat (10) @(posedge clk);
		$display("summary: %0d commands sent, %0d results checked, %0d positioning completions",
			sent_cnt, checked_cnt, done_cnt);
		$display("summary: %0d register writes, phases observed %b", reg_write_cnt, phases_seen);
		if (err_cnt == 0 && levels_due_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
